/* sv/fixed_block_free_list_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-size block allocator
// Shared checks written as clocked implications on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBFLA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FBFLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

/* sv/fbfla_pkg.sv */
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types, codes and helpers shared by the block allocator and its divider.
// ----------------------------------------------------------------------------
package fbfla_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int RING_DEPTH = MAX_BLOCKS + 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int IDX_W      = 8;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int WORDS_W    = 13;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int STAT_W     = 2;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 40;

    // The byte length is four times the word count, so the division drops
    // the two low offset bits and divides by the word count alone.
    localparam int DVD_W      = ADDR_W - 2;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam int PROD_W     = IDX_W + WORDS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT = 2'd0,
        CFG_WORDS = 2'd1,
        CFG_BASE  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC_RD,
        S_ALLOC_MUL,
        S_DIV,
        S_FREE_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Ring pointer step with wrap at the modulus; a pointer left beyond the
    // modulus by a count change also wraps to zero.
    function automatic logic [PTR_W-1:0] ring_advance(
        input logic [PTR_W-1:0] ptr,
        input logic [PTR_W-1:0] modulus
    );
        logic [PTR_W:0] inc;
        inc = {1'b0, ptr} + {{PTR_W{1'b0}}, 1'b1};
        if (inc >= {1'b0, modulus})
            return '0;
        return inc[PTR_W-1:0];
    endfunction

endpackage

/* sv/fbfla_div.sv */
// ----------------------------------------------------------------------------
// fbfla_div
// Restoring divider, one quotient bit per cycle, for offset to index mapping.
// ----------------------------------------------------------------------------
module fbfla_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [fbfla_pkg::DVD_W-1:0]       dividend,
    input  logic [fbfla_pkg::WORDS_W-1:0]     divisor,
    output fbfla_pkg::div_status_t            status,
    output logic [fbfla_pkg::DVD_W-1:0]       quotient
);
    import fbfla_pkg::*;

    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [WORDS_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [WORDS_W:0]   trial;

    // The quotient register starts out holding the dividend; its top bit
    // moves into the remainder as each quotient bit enters from below.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = WORDS_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORDS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

/* sv/fixed_block_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-size blocks handed out and taken back through a ring of free
// block indices.
// ----------------------------------------------------------------------------
// The block takes one word at a time and answers each with exactly one result
// word. An allocate from a nonempty pool takes the registered ring read, then
// multiplies the index by the block length, adds the base and loads the
// output register. A free runs the divider, which maps the offset to a block
// index one quotient bit per cycle, then sees it finish, checks the range and
// the ring space and loads the output register. An init writes the ring one
// entry per cycle through its single write port. A reserved kind or an
// allocate from an empty pool goes straight to the output register. The
// result word appears on the output in the cycle the input turns ready
// again. A result still held at the output stalls the following item in its
// last cycle, so the input stays not ready until the output has been taken.
// Until the first init the pool is empty, so an allocate reports no free
// block unless a free has put one back.
module fixed_block_free_list_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbfla_pkg::ADDR_W-1:0]        s_tdata,   // [31:0] address
    input  logic [fbfla_pkg::KIND_W-1:0]        s_tuser,   // [1:0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbfla_pkg::OUT_DATA_W-1:0]    m_tdata,   // [31:0] block_address,
                                                           // [39:32] block_index
    output logic [fbfla_pkg::STAT_W-1:0]        m_tuser,   // [1:0] status
    input  logic                                cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fbfla_pkg::*;

    state_t             state_reg, state_next;

    logic [COUNT_W-1:0] count_reg;
    logic [WORDS_W-1:0] words_reg;
    logic [ADDR_W-1:0]  base_reg;

    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   init_reg;

    logic [IDX_W-1:0]   ring [RING_DEPTH];
    logic [IDX_W-1:0]   rd_data_reg;
    logic               ring_we;
    logic [PTR_W-1:0]   ring_waddr;
    logic [IDX_W-1:0]   ring_wdata;

    logic [PROD_W-1:0]  prod_reg;

    status_t            res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [IDX_W-1:0]   res_idx_reg;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [IDX_W-1:0]   m_idx_reg;

    logic               div_start;
    div_status_t        div_status;
    logic [DVD_W-1:0]   div_quo;
    logic [ADDR_W-1:0]  offset;

    logic [COUNT_W-1:0] count_eff;
    logic [WORDS_W-1:0] words_eff;
    logic [PTR_W-1:0]   modulus;
    logic [PTR_W-1:0]   wp_adv;
    logic               accept;
    logic               out_free;
    logic               init_last;
    logic               idx_bad;
    kind_t              kind_in;

    // Out-of-range count saturates to the legal range; zero words acts as one.
    always_comb
    begin
        if (count_reg < COUNT_W'(2))
            count_eff = COUNT_W'(2);
        else if (count_reg > COUNT_W'(MAX_BLOCKS))
            count_eff = COUNT_W'(MAX_BLOCKS);
        else
            count_eff = count_reg;
        words_eff = (words_reg == '0) ? WORDS_W'(1) : words_reg;
    end

    assign modulus   = PTR_W'(count_eff) + PTR_W'(1);
    assign wp_adv    = ring_advance(wp_reg, modulus);
    assign kind_in   = kind_t'(s_tuser);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign init_last = (init_reg == PTR_W'(count_eff - COUNT_W'(1)));
    assign idx_bad   = (div_quo >= DVD_W'(count_eff));
    assign offset    = s_tdata - base_reg;

    fbfla_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset[ADDR_W-1:2]),
        .divisor  (words_eff),
        .status   (div_status),
        .quotient (div_quo)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_in)
                        KIND_INIT:  state_next = S_INIT;
                        KIND_ALLOC: state_next = (rp_reg == wp_reg) ? S_OUT : S_ALLOC_RD;
                        KIND_FREE:  state_next = S_DIV;
                        KIND_RSVD:  state_next = S_OUT;
                    endcase
                end
            end
            S_INIT:      state_next = init_last ? S_OUT : S_INIT;
            S_ALLOC_RD:  state_next = S_ALLOC_MUL;
            S_ALLOC_MUL: state_next = S_OUT;
            S_DIV:       state_next = div_status.done ? S_FREE_CHK : S_DIV;
            S_FREE_CHK:  state_next = S_OUT;
            S_OUT:       state_next = out_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready   = 1'b0;
        div_start  = 1'b0;
        ring_we    = 1'b0;
        ring_waddr = wp_reg;
        ring_wdata = div_quo[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (kind_in == KIND_FREE);
            end
            S_INIT:
            begin
                ring_we    = 1'b1;
                ring_waddr = init_reg;
                ring_wdata = init_reg[IDX_W-1:0];
            end
            S_FREE_CHK:
            begin
                ring_we = !idx_bad && (wp_adv != rp_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= COUNT_W'(2);
            words_reg <= WORDS_W'(1);
            base_reg  <= '0;
            rp_reg    <= '0;
            wp_reg    <= '0;
            init_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_WORDS: words_reg <= cfg_data[WORDS_W-1:0];
                    CFG_BASE:  base_reg  <= cfg_data[ADDR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    init_reg <= '0;
                end
                S_INIT:
                begin
                    init_reg <= init_reg + PTR_W'(1);
                    if (init_last)
                    begin
                        rp_reg <= '0;
                        wp_reg <= PTR_W'(count_eff);
                    end
                end
                S_ALLOC_MUL:
                begin
                    rp_reg <= ring_advance(rp_reg, modulus);
                end
                S_FREE_CHK:
                begin
                    if (ring_we)
                        wp_reg <= wp_adv;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result staging; payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                res_status_reg <= (kind_in == KIND_ALLOC) ? STAT_EMPTY : STAT_OK;
                res_addr_reg   <= '0;
                res_idx_reg    <= '0;
            end
            S_ALLOC_RD:
            begin
                prod_reg <= PROD_W'(rd_data_reg) * PROD_W'(words_eff);
            end
            S_ALLOC_MUL:
            begin
                res_status_reg <= STAT_OK;
                res_addr_reg   <= base_reg + ADDR_W'({prod_reg, 2'b00});
                res_idx_reg    <= rd_data_reg;
            end
            S_FREE_CHK:
            begin
                if (idx_bad)
                    res_status_reg <= STAT_BAD_ADDR;
                else if (wp_adv == rp_reg)
                    res_status_reg <= STAT_FULL;
                else
                begin
                    res_status_reg <= STAT_OK;
                    res_idx_reg    <= div_quo[IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Ring memory: one write port, read always at the read pointer.
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[ring_waddr] <= ring_wdata;
        rd_data_reg <= ring[rp_reg];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_idx_reg    <= res_idx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_idx_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

`include "fixed_block_free_list_allocator_assert.svh"

    `FBFLA_ASSERT_NEXT(a_one_item_at_a_time, accept, !s_tready)
    `FBFLA_ASSERT_SAME(a_pointers_in_ring, 1'b1,
        (rp_reg < PTR_W'(RING_DEPTH)) && (wp_reg < PTR_W'(RING_DEPTH)))
    `FBFLA_ASSERT_SAME(a_failure_zero_payload,
        m_tvalid && (m_tuser != STAT_OK), m_tdata == '0)
    `FBFLA_ASSERT_SAME(a_divider_only_in_div, div_status.busy, state_reg == S_DIV)

endmodule

/* dv/fixed_block_free_list_allocator_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block allocator checker
// Follows the input, output and register ports of the allocator, keeps its
// own copy of the free ring and pointers, and compares every reply word with
// the oldest predicted reply.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_check
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [fbfla_pkg::ADDR_W-1:0]        s_tdata,   // [31:0] address
    input  logic [fbfla_pkg::KIND_W-1:0]        s_tuser,   // [1:0] kind
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [fbfla_pkg::OUT_DATA_W-1:0]    m_tdata,   // [31:0] block_address,
                                                           // [39:32] block_index
    input  logic [fbfla_pkg::STAT_W-1:0]        m_tuser,   // [1:0] status
    input  logic                                cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int unsigned                         pending,
    output int unsigned                         errors
);
    import fbfla_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] addr;
    } reply_t;

    logic [IDX_W-1:0]   ring [RING_DEPTH];
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [COUNT_W-1:0] count_reg;
    logic [WORDS_W-1:0] words_reg;
    logic [ADDR_W-1:0]  base_reg;
    reply_t             replies [$];

    // A pointer left past the modulus by a count change also wraps to zero.
    function automatic logic [PTR_W-1:0] next_slot(
        input logic [PTR_W-1:0] ptr,
        input logic [PTR_W:0]   modulus
    );
        logic [PTR_W:0] inc;
        inc = {1'b0, ptr} + 1'b1;
        return (inc >= modulus) ? '0 : inc[PTR_W-1:0];
    endfunction

    task automatic step_pool(input kind_t kind, input logic [ADDR_W-1:0] addr);
        reply_t             r;
        logic [COUNT_W-1:0] cnt;
        logic [WORDS_W-1:0] words;
        logic [PTR_W:0]     modulus;
        logic [ADDR_W-1:0]  len;
        logic [ADDR_W-1:0]  idx;
        logic [PTR_W-1:0]   nxt;
        logic [PTR_W-1:0]   slot;
        r.status = STAT_OK;
        r.index  = '0;
        r.addr   = '0;
        if (count_reg < 2)
            cnt = 2;
        else if (count_reg > MAX_BLOCKS)
            cnt = MAX_BLOCKS;
        else
            cnt = count_reg;
        modulus = {1'b0, cnt} + 1'b1;
        words   = (words_reg == 0) ? 1 : words_reg;
        len     = {{(ADDR_W-WORDS_W-2){1'b0}}, words, 2'b00};
        case (kind)
            KIND_INIT:
            begin
                for (slot = 0; slot < cnt; slot++)
                    ring[slot] = slot[IDX_W-1:0];
                rd_ptr = '0;
                wr_ptr = cnt;
            end
            KIND_ALLOC:
            begin
                if (rd_ptr == wr_ptr)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.index = ring[rd_ptr];
                    r.addr  = base_reg + r.index * len;
                    rd_ptr  = next_slot(rd_ptr, modulus);
                end
            end
            KIND_FREE:
            begin
                // Addresses below the base wrap to huge offsets and fail the
                // range test like addresses past the pool.
                idx = (addr - base_reg) / len;
                if (idx >= cnt)
                    r.status = STAT_BAD_ADDR;
                else
                begin
                    nxt = next_slot(wr_ptr, modulus);
                    if (nxt == rd_ptr)
                        r.status = STAT_FULL;
                    else
                    begin
                        ring[wr_ptr] = idx[IDX_W-1:0];
                        wr_ptr       = nxt;
                        r.index      = idx[IDX_W-1:0];
                    end
                end
            end
            default:
                ;
        endcase
        replies.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            replies.delete();
            rd_ptr    = '0;
            wr_ptr    = '0;
            count_reg = 2;
            words_reg = 1;
            base_reg  = '0;
            errors    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.index  = m_tdata[ADDR_W +: IDX_W];
                got.addr   = m_tdata[ADDR_W-1:0];
                if (replies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected reply word: status %0d index %0d address %h",
                                 got.status, got.index, got.addr);
                end
                else
                begin
                    want = replies.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("reply mismatch: expected %0d/%0d/%h, got %0d/%0d/%h",
                                     want.status, want.index, want.addr,
                                     got.status, got.index, got.addr);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    CFG_WORDS: words_reg = cfg_data[WORDS_W-1:0];
                    CFG_BASE:  base_reg  = cfg_data[ADDR_W-1:0];
                    default:   ;
                endcase
            end
            if (s_tvalid && s_tready)
                step_pool(kind_t'(s_tuser), s_tdata);
        end
        pending = replies.size();
    end

endmodule

/* dv/fixed_block_free_list_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block allocator testbench
// Drives init, allocate, free and reserved words into the allocator under
// changing pool settings, with random idling on both streams and one long
// output stall, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_test;
    import fbfla_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 800000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned TAIL_CYCLES  = 60;
    localparam int unsigned RANDOM_ITEMS = 600;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int unsigned           pending;
    int unsigned           errors;

    logic                  calm      = 1'b0;
    logic                  hold_arm  = 1'b0;
    logic                  hold_used = 1'b0;
    int unsigned           hold_left = 0;
    int unsigned           cycles    = 0;
    int unsigned           sent      = 0;

    // Pool setting as last written, used to aim free addresses at blocks.
    logic [COUNT_W-1:0]    set_count = 2;
    logic [WORDS_W-1:0]    set_words = 1;
    logic [ADDR_W-1:0]     set_base  = '0;

    always #6 clk = ~clk;

    fixed_block_free_list_allocator u_top (.*);

    fixed_block_free_list_allocator_check u_check (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Output side: random stalls, none while calm, and one long hold-off
    // during which the allocator backs up onto its input.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    function automatic int unsigned eff_count();
        if (set_count < 2)
            return 2;
        if (set_count > MAX_BLOCKS)
            return MAX_BLOCKS;
        return set_count;
    endfunction

    function automatic logic [ADDR_W-1:0] byte_len();
        logic [WORDS_W-1:0] w;
        w = (set_words == 0) ? 1 : set_words;
        return {{(ADDR_W-WORDS_W-2){1'b0}}, w, 2'b00};
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
        return set_base + idx * byte_len();
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Unused upper data bits carry random values; the registers keep only
    // their own width.
    task automatic load_setting(
        input logic [COUNT_W-1:0] c,
        input logic [WORDS_W-1:0] w,
        input logic [ADDR_W-1:0]  b,
        input bit                 spare
    );
        logic [CFG_DATA_W-1:0] val;
        set_count = c;
        set_words = w;
        set_base  = b;
        val = $urandom;
        val[COUNT_W-1:0] = c;
        set_reg(CFG_COUNT, val);
        val = $urandom;
        val[WORDS_W-1:0] = w;
        set_reg(CFG_WORDS, val);
        set_reg(CFG_BASE, b);
        if (spare)
            set_reg(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input kind_t kind, input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat ($urandom_range(1, 45))
                @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted reply has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned       r;
        int unsigned       ec;
        logic [ADDR_W-1:0] len;
        ec  = eff_count();
        len = byte_len();
        r   = $urandom_range(0, 99);
        if (r < 42)
            send_word(KIND_ALLOC, $urandom);
        else if (r < 80)
            send_word(KIND_FREE, block_addr($urandom_range(0, ec - 1)) +
                                 $urandom_range(0, len - 1));
        else if (r < 87)
            send_word(KIND_FREE, set_base - $urandom_range(1, 4096));
        else if (r < 91)
            send_word(KIND_FREE, block_addr(ec) + $urandom_range(0, 3 * len));
        else if (r < 95)
            send_word(KIND_FREE, $urandom);
        else if (r < 98)
            send_word(KIND_INIT, $urandom);
        else
            send_word(KIND_RSVD, $urandom);
    endtask

    initial
    begin : stimulus
        int unsigned        last_item;
        int unsigned        phase;
        int unsigned        n;
        logic [COUNT_W-1:0] c;
        logic [WORDS_W-1:0] w;
        logic [ADDR_W-1:0]  b;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, before any init: the pool starts empty.
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_RSVD, '1);
        send_word(KIND_FREE, 32'd4);
        send_word(KIND_ALLOC, '0);
        drain();

        // Largest pool, a block of 4096 words, base near the top so addresses wrap.
        load_setting(9'd256, 13'd4096, 32'hFFFF_F000, 1'b0);
        send_word(KIND_INIT, '0);
        send_word(KIND_FREE, set_base);
        send_word(KIND_ALLOC, $urandom);
        // The last byte of the last block lands in the one ring slot that
        // init leaves unwritten, so later count changes never read garbage.
        send_word(KIND_FREE, block_addr(255) + byte_len() - 1);
        send_word(KIND_FREE, block_addr(256));
        send_word(KIND_FREE, set_base - 4);
        send_word(KIND_ALLOC, '0);
        drain();

        // Count and length below range, changed without a new init.
        load_setting(9'd0, 13'd0, 32'd0, 1'b0);
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_FREE, 32'd7);
        send_word(KIND_FREE, 32'd0);
        send_word(KIND_FREE, 32'd4);
        drain();

        // Count above range, the largest length, plus a write to the spare index.
        load_setting(9'd511, 13'd8191, 32'd0, 1'b1);
        send_word(KIND_INIT, $urandom);
        send_word(KIND_ALLOC, '1);
        send_word(KIND_FREE, '1);
        send_word(KIND_FREE, block_addr(200) + 5);
        send_word(KIND_RSVD, $urandom);
        drain();

        load_setting(9'd2, 13'd1, 32'hFFFF_FFFC, 1'b0);
        send_word(KIND_INIT, '0);
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_ALLOC, $urandom);
        send_word(KIND_FREE, 32'd0);
        drain();

        last_item = sent + RANDOM_ITEMS;
        phase     = 0;
        while (sent < last_item)
        begin
            case ($urandom_range(0, 9))
                0:       c = 9'd2;
                1:       c = 9'd256;
                2:       c = $urandom_range(0, 1);
                3:       c = $urandom_range(257, 511);
                4, 5, 6: c = $urandom_range(3, 8);
                default: c = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 7))
                0:       w = 13'd1;
                1:       w = 13'd4096;
                2:       w = 13'd0;
                3:       w = 13'd8191;
                default: w = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 5))
                0:       b = '0;
                1:       b = '1;
                2:       b = 32'hFFFF_FF00 + $urandom_range(0, 255);
                default: b = $urandom;
            endcase
            calm <= (phase == 3);
            load_setting(c, w, b, phase == 5);
            if ($urandom_range(0, 9) < 8)
                send_word(KIND_INIT, $urandom);
            n = $urandom_range(20, 60);
            for (int k = 0; k < n; k++)
            begin
                if (phase == 1 && k == 4)
                    hold_arm <= 1'b1;
                send_random();
            end
            drain();
            phase++;
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
